// ===== rtl/mcstb_pkg.sv =====
// Package for the timer bank: sizes, request codes and lane interface types.
`default_nettype none
package mcstb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int REQ_W      = 3;
    localparam int CH_W       = 3;
    localparam int CNT_W      = 32;

    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_OPEN       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_MATCH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_OVF   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ_COUNT = 3'd5;

    // Command to one timer lane for the current cycle.
    typedef struct packed {
        logic             tick;
        logic             open;
        logic             close;
        logic             clr_match;
        logic             clr_ovf;
        logic             use_compare;
        logic [CNT_W-1:0] compare_value;
    } lane_cmd_t;

    // State a lane exposes for reads and open checks.
    typedef struct packed {
        logic             enabled;
        logic             match_flag;
        logic             ovf_flag;
        logic [CNT_W-1:0] count;
    } lane_stat_t;

endpackage
`default_nettype wire

// ===== rtl/mcstb_timer.sv =====
// One timer lane: count, compare value, mode, enable and sticky flags.
`default_nettype none
module mcstb_timer
    import mcstb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lane_cmd_t  cmd,
    output lane_stat_t      stat
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] match_value_reg, match_value_next;
    logic             enabled_reg, enabled_next;
    logic             cmp_mode_reg, cmp_mode_next;
    logic             ovf_reg, ovf_next;
    logic             match_reg, match_next;
    logic [CNT_W-1:0] count_inc;

    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        count_next       = count_reg;
        match_value_next = match_value_reg;
        enabled_next     = enabled_reg;
        cmp_mode_next    = cmp_mode_reg;
        ovf_next         = ovf_reg;
        match_next       = match_reg;
        if (cmd.tick && enabled_reg)
        begin
            count_next = count_inc;
            if (count_inc == '0)
            begin
                ovf_next = 1'b1;
            end
            // compare after the wrap check: a zero compare value matches on wrap
            if (cmp_mode_reg && (count_inc == match_value_reg))
            begin
                count_next = '0;
                match_next = 1'b1;
            end
        end
        if (cmd.open)
        begin
            enabled_next  = 1'b1;
            cmp_mode_next = cmd.use_compare;
            if (cmd.use_compare)
            begin
                match_value_next = cmd.compare_value;
            end
        end
        if (cmd.close)
        begin
            enabled_next = 1'b0;
        end
        if (cmd.clr_match)
        begin
            match_next = 1'b0;
        end
        if (cmd.clr_ovf)
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            match_value_reg <= '0;
            enabled_reg     <= 1'b0;
            cmp_mode_reg    <= 1'b0;
            ovf_reg         <= 1'b0;
            match_reg       <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            match_value_reg <= match_value_next;
            enabled_reg     <= enabled_next;
            cmp_mode_reg    <= cmp_mode_next;
            ovf_reg         <= ovf_next;
            match_reg       <= match_next;
        end
    end

    assign stat.enabled    = enabled_reg;
    assign stat.match_flag = match_reg;
    assign stat.ovf_flag   = ovf_reg;
    assign stat.count      = count_reg;

endmodule
`default_nettype wire

// ===== rtl/multi_channel_soft_timer_bank.sv =====
// Top level of the timer bank: request register, lane decode, result register.
//
// Usage: drive req_type, channel, use_compare and compare_value and raise
// start. A request transfers at a rising edge with start high and busy low;
// busy is always low, so one request can transfer every cycle.
// Requests: tick steps every enabled timer, open/close enable or disable a
// timer, the two flag reads return and clear a flag, count read returns the
// count. Tick and unused codes give no result.
// The request is registered at its transfer edge, the timers update and the
// result register loads at the next edge, so done, status and read_value
// come from the result register and are valid for exactly one cycle.
// Throughput is one request per cycle; all lanes update in parallel.
// The receiver cannot stall: a result is on the ports for one cycle only.
// Reset (rst_n low, asynchronous) clears every count, compare value, enable,
// mode and flag, and drops any request in flight.
`default_nettype none
module multi_channel_soft_timer_bank
    import mcstb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire logic [CH_W-1:0]  channel,
    input  wire logic             use_compare,
    input  wire logic [CNT_W-1:0] compare_value,
    output logic                  done,
    output logic                  status,
    output logic [CNT_W-1:0]      read_value
);

    logic             req_vld_reg;
    logic [REQ_W-1:0] req_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             cmp_reg;
    logic [CNT_W-1:0] cval_reg;

    logic             done_reg, done_next;
    logic             status_reg, status_next;
    logic [CNT_W-1:0] value_reg, value_next;

    lane_cmd_t  lane_cmd  [NUM_TIMERS];
    lane_stat_t lane_stat [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] lane_hit;
    logic                  ch_valid;
    lane_stat_t            sel_stat;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            req_reg     <= REQ_TICK;
            ch_reg      <= '0;
            cmp_reg     <= 1'b0;
            cval_reg    <= '0;
        end
        else
        begin
            req_vld_reg <= start && !busy;
            if (start && !busy)
            begin
                req_reg  <= req_type;
                ch_reg   <= channel;
                cmp_reg  <= use_compare;
                cval_reg <= compare_value;
            end
        end
    end

    assign ch_valid = int'(ch_reg) < NUM_TIMERS;

    always_comb
    begin
        sel_stat = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            lane_hit[i] = req_vld_reg && (int'(ch_reg) == i);
            if (lane_hit[i])
            begin
                sel_stat = sel_stat | lane_stat[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_lane
        always_comb
        begin
            lane_cmd[g].tick          = req_vld_reg && (req_reg == REQ_TICK);
            lane_cmd[g].open          = lane_hit[g] && (req_reg == REQ_OPEN)
                                        && !lane_stat[g].enabled;
            lane_cmd[g].close         = lane_hit[g] && (req_reg == REQ_CLOSE);
            lane_cmd[g].clr_match     = lane_hit[g] && (req_reg == REQ_READ_MATCH);
            lane_cmd[g].clr_ovf       = lane_hit[g] && (req_reg == REQ_READ_OVF);
            lane_cmd[g].use_compare   = cmp_reg;
            lane_cmd[g].compare_value = cval_reg;
        end

        mcstb_timer u_timer (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (lane_cmd[g]),
            .stat  (lane_stat[g])
        );
    end

    always_comb
    begin
        done_next   = 1'b0;
        status_next = 1'b0;
        value_next  = '0;
        if (req_vld_reg)
        begin
            unique case (req_reg)
                REQ_OPEN:
                begin
                    done_next   = 1'b1;
                    status_next = !ch_valid || sel_stat.enabled;
                end
                REQ_CLOSE:
                begin
                    done_next = 1'b1;
                end
                REQ_READ_MATCH:
                begin
                    done_next  = 1'b1;
                    value_next = CNT_W'(sel_stat.match_flag);
                end
                REQ_READ_OVF:
                begin
                    done_next  = 1'b1;
                    value_next = CNT_W'(sel_stat.ovf_flag);
                end
                REQ_READ_COUNT:
                begin
                    done_next  = 1'b1;
                    value_next = sel_stat.count;
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= 1'b0;
            value_reg  <= '0;
        end
        else
        begin
            done_reg   <= done_next;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = value_reg;

`ifndef SYNTHESIS
    // a result only follows a registered request
    a_done_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req_vld_reg))
        else $error("result without a request");

    // a rejection is only reported for an open
    a_reject_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> ($past(req_reg) == REQ_OPEN))
        else $error("reject status on a non-open request");

    // result payload is quiet between strobes
    a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!status && (read_value == '0)))
        else $error("result payload active without strobe");

    // a tick never gives a result
    a_no_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && (req_reg == REQ_TICK)) |=> !done)
        else $error("result produced for a tick");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the timer bank: queued request driver, result monitor, predictor.
`default_nettype none
module testbench;
    import mcstb_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_TAIL    = 300;
    localparam int MAX_REPORTS  = 10;

    // Request codes the block ignores.
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [CH_W-1:0]  ch;
        logic             cmp;
        logic [CNT_W-1:0] cval;
        int               gap;
    } timer_req_t;

    typedef struct {
        logic             status;
        logic [CNT_W-1:0] value;
    } timer_resp_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             start         = 1'b0;
    logic [REQ_W-1:0] req_type      = '0;
    logic [CH_W-1:0]  channel       = '0;
    logic             use_compare   = 1'b0;
    logic [CNT_W-1:0] compare_value = '0;
    logic             busy;
    logic             done;
    logic             status;
    logic [CNT_W-1:0] read_value;

    multi_channel_soft_timer_bank dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .channel      (channel),
        .use_compare  (use_compare),
        .compare_value(compare_value),
        .done         (done),
        .status       (status),
        .read_value   (read_value)
    );

    // Predicted timer state
    logic [CNT_W-1:0] tmr_count     [NUM_TIMERS];
    logic [CNT_W-1:0] tmr_match_val [NUM_TIMERS];
    logic             tmr_enabled   [NUM_TIMERS];
    logic             tmr_cmp_mode  [NUM_TIMERS];
    logic             tmr_ovf       [NUM_TIMERS];
    logic             tmr_match     [NUM_TIMERS];

    timer_req_t  pending_reqs[$];
    timer_resp_t expected_results[$];

    int          hold_off     = 0;
    int          reqs_sent    = 0;
    int          results_seen = 0;
    int          flags_hit    = 0;
    int          bad_cnt      = 0;
    int          cycle_cnt    = 0;
    timer_req_t  next_req;
    timer_resp_t want;

    initial begin
        forever #5 clk = ~clk;
    end

    // Apply one transferred request to the predicted state; queue its result if any.
    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                                   input logic cmp, input logic [CNT_W-1:0] cval);
        timer_resp_t r;
        bit          has_result;
        bit          ch_ok;
        r.status   = 1'b0;
        r.value    = '0;
        has_result = 1'b1;
        ch_ok      = (ch < NUM_TIMERS);
        case (req)
            REQ_TICK: begin
                has_result = 1'b0;
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (tmr_enabled[t]) begin
                        tmr_count[t] = tmr_count[t] + 1'b1;
                        if (tmr_count[t] == '0)
                            tmr_ovf[t] = 1'b1;
                        if (tmr_cmp_mode[t] && tmr_count[t] == tmr_match_val[t]) begin
                            tmr_count[t] = '0;
                            tmr_match[t] = 1'b1;
                        end
                    end
                end
            end
            REQ_OPEN: begin
                if (!ch_ok || tmr_enabled[ch])
                    r.status = 1'b1;
                else begin
                    tmr_enabled[ch]  = 1'b1;
                    tmr_cmp_mode[ch] = cmp;
                    if (cmp)
                        tmr_match_val[ch] = cval;
                end
            end
            REQ_CLOSE: begin
                if (ch_ok)
                    tmr_enabled[ch] = 1'b0;
            end
            REQ_READ_MATCH: begin
                if (ch_ok) begin
                    r.value       = {{(CNT_W-1){1'b0}}, tmr_match[ch]};
                    flags_hit    += int'(tmr_match[ch]);
                    tmr_match[ch] = 1'b0;
                end
            end
            REQ_READ_OVF: begin
                if (ch_ok) begin
                    r.value     = {{(CNT_W-1){1'b0}}, tmr_ovf[ch]};
                    flags_hit  += int'(tmr_ovf[ch]);
                    tmr_ovf[ch] = 1'b0;
                end
            end
            REQ_READ_COUNT: begin
                if (ch_ok)
                    r.value = tmr_count[ch];
            end
            default: has_result = 1'b0;
        endcase
        if (has_result)
            expected_results.push_back(r);
    endtask

    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                                 input logic cmp, input logic [CNT_W-1:0] cval, input int gap);
        timer_req_t q;
        q.req  = req;
        q.ch   = ch;
        q.cmp  = cmp;
        q.cval = cval;
        q.gap  = gap;
        pending_reqs.push_back(q);
    endtask

    // Mostly ticks, opens in compare mode with short periods, and reads; a little noise.
    function automatic timer_req_t random_request(input bit with_gap);
        timer_req_t q;
        int         roll;
        int         vroll;
        roll   = $urandom_range(0, 99);
        vroll  = $urandom_range(0, 99);
        q.ch   = CH_W'($urandom_range(0, NUM_TIMERS - 1));
        q.cmp  = 1'($urandom);
        q.cval = $urandom;
        q.gap  = 0;
        if (roll < 38)
            q.req = REQ_TICK;
        else if (roll < 53) begin
            q.req = REQ_OPEN;
            q.cmp = ($urandom_range(0, 99) < 80);
            if (vroll < 60)
                q.cval = $urandom_range(1, 24);
            else if (vroll < 75)
                q.cval = (vroll < 65) ? 32'h0 : (vroll < 70) ? 32'hFFFF_FFFF : 32'h1;
        end
        else if (roll < 61)
            q.req = REQ_CLOSE;
        else if (roll < 73)
            q.req = REQ_READ_MATCH;
        else if (roll < 81)
            q.req = REQ_READ_OVF;
        else if (roll < 95)
            q.req = REQ_READ_COUNT;
        else
            q.req = ($urandom_range(0, 1) != 0) ? REQ_SPARE6 : REQ_SPARE7;
        if (with_gap && $urandom_range(0, 99) < 15)
            q.gap = $urandom_range(1, 18);
        return q;
    endfunction

    // Driver: one transfer per cycle unless a burst of idle cycles is pending.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start    <= 1'b0;
            hold_off <= 0;
        end
        else begin
            if (start && !busy) begin
                predict_request(req_type, channel, use_compare, compare_value);
                reqs_sent++;
            end
            if (start && busy) begin
                // hold the request until it transfers
            end
            else if (hold_off != 0 ||
                     (pending_reqs.size() != 0 && pending_reqs[0].gap != 0)) begin
                if (hold_off != 0)
                    hold_off <= hold_off - 1;
                else begin
                    hold_off            <= pending_reqs[0].gap - 1;
                    pending_reqs[0].gap  = 0;
                end
                start         <= 1'b0;
                req_type      <= REQ_W'($urandom);
                channel       <= CH_W'($urandom);
                use_compare   <= 1'($urandom);
                compare_value <= $urandom;
            end
            else if (pending_reqs.size() != 0) begin
                next_req       = pending_reqs.pop_front();
                start         <= 1'b1;
                req_type      <= next_req.req;
                channel       <= next_req.ch;
                use_compare   <= next_req.cmp;
                compare_value <= next_req.cval;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result is matched against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= MAX_REPORTS)
                    $display("ERROR: result with nothing expected: status=%0d read_value=%h",
                             status, read_value);
            end
            else begin
                want = expected_results.pop_front();
                results_seen++;
                if (status !== want.status || read_value !== want.value) begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_REPORTS) begin
                        $display("ERROR: result %0d: expected status=%0d read_value=%h,",
                                 results_seen, want.status, want.value);
                        $display("       got status=%0d read_value=%h", status, read_value);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        bit calm;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            tmr_count[t]     = '0;
            tmr_match_val[t] = '0;
            tmr_enabled[t]   = 1'b0;
            tmr_cmp_mode[t]  = 1'b0;
            tmr_ovf[t]       = 1'b0;
            tmr_match[t]     = 1'b0;
        end

        // Directed: reads after reset, ignored codes, rejected open, free-run open,
        // compare values zero and one, match and flag clear on read, close and reopen.
        queue_request(REQ_READ_COUNT, 3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_MATCH, 3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_OVF,   3'd7, 1'b1, 32'hFFFF_FFFF, 0);
        queue_request(REQ_CLOSE,      3'd7, 1'b0, 32'h0, 0);
        queue_request(REQ_SPARE6,     3'd2, 1'b1, 32'hFFFF_FFFF, 0);
        queue_request(REQ_SPARE7,     3'd5, 1'b0, 32'h0, 0);
        queue_request(REQ_TICK,       3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_OPEN,       3'd0, 1'b1, 32'd3, 0);
        queue_request(REQ_OPEN,       3'd0, 1'b1, 32'd9, 0);
        queue_request(REQ_OPEN,       3'd1, 1'b0, 32'hFFFF_FFFF, 0);
        queue_request(REQ_OPEN,       3'd2, 1'b1, 32'h0, 0);
        queue_request(REQ_OPEN,       3'd7, 1'b1, 32'd1, 0);
        queue_request(REQ_TICK,       3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_TICK,       3'd0, 1'b0, 32'h0, 3);
        queue_request(REQ_TICK,       3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_TICK,       3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_MATCH, 3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_MATCH, 3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_COUNT, 3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_COUNT, 3'd1, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_COUNT, 3'd2, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_MATCH, 3'd7, 1'b0, 32'h0, 0);
        queue_request(REQ_READ_OVF,   3'd1, 1'b0, 32'h0, 0);
        queue_request(REQ_CLOSE,      3'd0, 1'b0, 32'h0, 0);
        queue_request(REQ_OPEN,       3'd0, 1'b0, 32'h5A5A_A5A5, 0);
        queue_request(REQ_READ_COUNT, 3'd0, 1'b0, 32'h0, 0);

        // Random: idle bursts switched on and off per block, none in the tail.
        calm = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);
            pending_reqs.push_back(random_request(!calm && i < RANDOM_ITEMS - CALM_TAIL));
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests covering every request code and all channels;", reqs_sent);
        $display("checked %0d results, %0d flag reads found a flag set.", results_seen, flags_hit);
        if (bad_cnt == 0)
            $display("Test completed successfully");
        else begin
            $display("%0d mismatches in total", bad_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
